// ----- design/nmea_rmc_field_splitter_assert.svh -----
// assertion macros for the nmea rmc field splitter checker
`ifndef NMEA_RMC_FIELD_SPLITTER_ASSERT_SVH
`define NMEA_RMC_FIELD_SPLITTER_ASSERT_SVH

// checked only outside reset
`define NRMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked in every cycle, reset included
`define NRMC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/nrmc_pkg.sv -----
// types and constants shared by the nmea rmc field splitter modules
package nrmc_pkg;

  localparam int unsigned FIELD_W = 4;
  localparam int unsigned OFF_W   = 5;
  localparam int unsigned TPOS_W  = 3;
  localparam int unsigned TYPE_W  = 48;

  localparam logic [TPOS_W-1:0]  TYPE_CHARS = 3'd6;
  localparam logic [FIELD_W-1:0] LAST_FIELD = 4'd10;
  localparam logic [7:0]         COMMA_CHAR = 8'h2C;
  localparam logic [TYPE_W-1:0]  TYPE_RESET = 48'h244750524D43;

  localparam logic [FIELD_W-1:0] FIELD_TYPE = 4'd0;
  localparam logic [FIELD_W-1:0] FIELD_TIME = 4'd1;
  localparam logic [FIELD_W-1:0] FIELD_LAT  = 4'd3;
  localparam logic [FIELD_W-1:0] FIELD_LON  = 4'd5;
  localparam logic [FIELD_W-1:0] FIELD_DATE = 4'd9;

  typedef struct packed {
    logic [FIELD_W-1:0] field_index;
    logic [OFF_W-1:0]   offset_in_field;
    logic [TPOS_W-1:0]  type_position;
    logic               type_still_matches;
    logic               latitude_seen;
  } sent_state_t;

  localparam sent_state_t SENT_RESET = '{
    field_index:        '0,
    offset_in_field:    '0,
    type_position:      '0,
    type_still_matches: 1'b1,
    latitude_seen:      1'b0
  };

  typedef struct packed {
    logic [FIELD_W-1:0] field_number;
    logic [OFF_W-1:0]   char_offset;
    logic [7:0]         char_value;
    logic               store_enable;
    logic               overflow;
    logic               is_last;
    logic               sentence_is_rmc;
    logic               latitude_present;
  } result_t;

endpackage

// ----- design/nrmc_step.sv -----
// per-byte field tagging, capacity check and type compare
module nrmc_step #(
  parameter int LONG_FIELD_CHARS  = 19,
  parameter int SHORT_FIELD_CHARS = 9
) (
  input  logic [7:0]                  byte_i,
  input  logic                        last_i,
  input  logic [nrmc_pkg::TYPE_W-1:0] expected_type_i,
  input  nrmc_pkg::sent_state_t       state_i,
  output nrmc_pkg::sent_state_t       state_o,
  output nrmc_pkg::result_t           result_o
);

  localparam logic [nrmc_pkg::OFF_W-1:0] LongCap  = nrmc_pkg::OFF_W'(LONG_FIELD_CHARS);
  localparam logic [nrmc_pkg::OFF_W-1:0] ShortCap = nrmc_pkg::OFF_W'(SHORT_FIELD_CHARS);

  nrmc_pkg::sent_state_t        nxt;
  logic [nrmc_pkg::OFF_W-1:0]   cap;
  logic [7:0]                   want;
  logic                         store;
  logic                         ovf;
  logic [nrmc_pkg::OFF_W-1:0]   off_out;

  // expected character for the current type position, first char in top byte
  always_comb begin
    case (state_i.type_position)
      3'd0:    want = expected_type_i[47:40];
      3'd1:    want = expected_type_i[39:32];
      3'd2:    want = expected_type_i[31:24];
      3'd3:    want = expected_type_i[23:16];
      3'd4:    want = expected_type_i[15:8];
      3'd5:    want = expected_type_i[7:0];
      default: want = '0;
    endcase
  end

  always_comb begin
    if (state_i.field_index == nrmc_pkg::FIELD_TIME || state_i.field_index == nrmc_pkg::FIELD_LAT
        || state_i.field_index == nrmc_pkg::FIELD_LON
        || state_i.field_index == nrmc_pkg::FIELD_DATE) begin
      cap = LongCap;
    end else begin
      cap = ShortCap;
    end
  end

  always_comb begin
    nxt     = state_i;
    store   = 1'b0;
    ovf     = 1'b0;
    off_out = '0;
    if (byte_i == nrmc_pkg::COMMA_CHAR) begin
      if (state_i.field_index < nrmc_pkg::LAST_FIELD) begin
        nxt.field_index = state_i.field_index + 1'b1;
      end
      nxt.offset_in_field = '0;
    end else begin
      off_out = state_i.offset_in_field;
      if (state_i.field_index == nrmc_pkg::FIELD_TYPE
          || state_i.field_index >= nrmc_pkg::LAST_FIELD) begin
        if (state_i.field_index == nrmc_pkg::FIELD_TYPE) begin
          if (state_i.type_position < nrmc_pkg::TYPE_CHARS) begin
            if (want != byte_i) begin
              nxt.type_still_matches = 1'b0;
            end
            nxt.type_position = state_i.type_position + 1'b1;
          end else begin
            nxt.type_still_matches = 1'b0;
          end
        end
        // offset saturates at the long capacity in type and trailing fields
        if (state_i.offset_in_field < LongCap) begin
          nxt.offset_in_field = state_i.offset_in_field + 1'b1;
        end
      end else begin
        if (state_i.offset_in_field < cap) begin
          store               = 1'b1;
          nxt.offset_in_field = state_i.offset_in_field + 1'b1;
        end else begin
          ovf = 1'b1;
        end
        if (state_i.field_index == nrmc_pkg::FIELD_LAT) begin
          nxt.latitude_seen = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result_o.field_number     = nxt.field_index;
    result_o.char_offset      = off_out;
    result_o.char_value       = byte_i;
    result_o.store_enable     = store;
    result_o.overflow         = ovf;
    result_o.is_last          = last_i;
    result_o.sentence_is_rmc  = last_i && nxt.type_still_matches
                                && (nxt.type_position == nrmc_pkg::TYPE_CHARS);
    result_o.latitude_present = last_i && nxt.latitude_seen;
  end

  // a new sentence starts after the last byte
  assign state_o = last_i ? nrmc_pkg::SENT_RESET : nxt;

endmodule

// ----- design/nmea_rmc_field_splitter.sv -----
// nmea rmc field splitter: input register, per-byte step logic and result register
// path: an accepted byte waits in the input register until the result register can take its result
// throughput: one byte per cycle, limited only by the result register handshake
// reset: sentence counters clear, expected type returns to "$GPRMC", both stages empty
// config writes are always taken; write only while no byte is in flight
module nmea_rmc_field_splitter #(
  parameter int LONG_FIELD_CHARS  = 19,
  parameter int SHORT_FIELD_CHARS = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [47:0] cfg_data_i,     // expected_type[47:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // field_number[3:0], char_offset[8:4], char_value[16:9], store_enable[17],
  // overflow[18], sentence_is_rmc[19], latitude_present[20], zero[23:21]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [nrmc_pkg::TYPE_W-1:0] exp_type_q;
  nrmc_pkg::sent_state_t       state_q;
  nrmc_pkg::sent_state_t       state_d;
  logic                        in_valid_q;
  logic [7:0]                  in_byte_q;
  logic                        in_last_q;
  logic                        out_valid_q;
  nrmc_pkg::result_t           out_q;
  nrmc_pkg::result_t           out_d;
  logic                        out_free;
  logic                        advance;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_type_q <= nrmc_pkg::TYPE_RESET;
    end else if (cfg_valid_i) begin
      exp_type_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  nrmc_step #(
    .LONG_FIELD_CHARS (LONG_FIELD_CHARS),
    .SHORT_FIELD_CHARS(SHORT_FIELD_CHARS)
  ) u_step (
    .byte_i         (in_byte_q),
    .last_i         (in_last_q),
    .expected_type_i(exp_type_q),
    .state_i        (state_q),
    .state_o        (state_d),
    .result_o       (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nrmc_pkg::SENT_RESET;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.is_last;
  assign m_axis_tdata  = {3'b000, out_q.latitude_present, out_q.sentence_is_rmc,
                          out_q.overflow, out_q.store_enable, out_q.char_value,
                          out_q.char_offset, out_q.field_number};

endmodule

// ----- design/nrmc_checker.sv -----
// port-level checks for the nmea rmc field splitter, bound to the top level
`include "nmea_rmc_field_splitter_assert.svh"

module nrmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // reset clears the result register
  `NRMC_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

  `NRMC_ASSERT(a_stall_holds,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "stalled result changed")

  `NRMC_ASSERT(a_store_xor_ovf, m_axis_tvalid |-> !(m_axis_tdata[17] && m_axis_tdata[18]),
    "store and overflow together")

  `NRMC_ASSERT(a_flags_on_last, m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[20:19] == 2'b00,
    "sentence flags before last byte")

  `NRMC_ASSERT(a_store_in_data,
    m_axis_tvalid && (m_axis_tdata[17] || m_axis_tdata[18]) |->
      m_axis_tdata[3:0] != 4'd0 && m_axis_tdata[3:0] < 4'd10,
    "store outside data fields")

endmodule

bind nmea_rmc_field_splitter nrmc_checker u_nrmc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

// ----- tb/sv/tb_nmea_rmc_field_splitter.sv -----
// self-checking testbench for the nmea rmc field splitter: directed table, then random sentences
`timescale 1ns / 100ps

module tb_nmea_rmc_field_splitter;

  localparam int LONG_CHARS  = 19;
  localparam int SHORT_CHARS = 9;

  // field numbers the package does not name
  localparam logic [nrmc_pkg::FIELD_W-1:0] FIELD_VALID = 4'd2;
  localparam logic [nrmc_pkg::FIELD_W-1:0] FIELD_NS    = 4'd4;

  localparam logic [nrmc_pkg::TYPE_W-1:0] TYPE_GNRMC = 48'h24474E524D43;
  localparam int PHASES        = 6;
  localparam int PHASE_BYTES   = 170;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int MAX_PRINTS    = 40;

  typedef struct {
    logic [7:0]        ch;
    logic              last;
    logic              typed;
    nrmc_pkg::result_t want;
  } byte_req_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [47:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // byte_value[7:0]
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // field_number[3:0], char_offset[8:4], char_value[16:9], store_enable[17],
  // overflow[18], sentence_is_rmc[19], latitude_present[20], zero[23:21]
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  nmea_rmc_field_splitter #(
    .LONG_FIELD_CHARS (LONG_CHARS),
    .SHORT_FIELD_CHARS(SHORT_CHARS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // splitter state as the testbench sees it
  logic [nrmc_pkg::TYPE_W-1:0]  acc_type;
  logic [nrmc_pkg::FIELD_W-1:0] cur_field;
  logic [nrmc_pkg::OFF_W-1:0]   cur_off;
  logic [nrmc_pkg::TPOS_W-1:0]  type_pos;
  logic                         type_ok;
  logic                         lat_seen;

  byte_req_t         table_rows[$];
  byte_req_t         byte_q[$];
  byte_req_t         on_bus;
  nrmc_pkg::result_t pending_q[$];

  int  err_count = 0;
  int  src_idle_pct = 26;
  int  snk_idle_pct = 62;
  bit  hold_arm = 1'b0;
  logic sink_blocked = 1'b0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  function automatic void clear_sentence();
    cur_field = '0;
    cur_off   = '0;
    type_pos  = '0;
    type_ok   = 1'b1;
    lat_seen  = 1'b0;
  endfunction

  function automatic nrmc_pkg::result_t split_byte(input logic [7:0] ch, input logic last);
    nrmc_pkg::result_t r;
    int                sh;
    int                cap;
    r = '0;
    r.char_value = ch;
    r.is_last    = last;
    if (ch == nrmc_pkg::COMMA_CHAR) begin
      if (cur_field < nrmc_pkg::LAST_FIELD) cur_field = cur_field + 1'b1;
      cur_off = '0;
      r.field_number = cur_field;
    end else begin
      r.field_number = cur_field;
      r.char_offset  = cur_off;
      if (cur_field == nrmc_pkg::FIELD_TYPE || cur_field >= nrmc_pkg::LAST_FIELD) begin
        if (cur_field == nrmc_pkg::FIELD_TYPE) begin
          if (type_pos < nrmc_pkg::TYPE_CHARS) begin
            sh = (int'(nrmc_pkg::TYPE_CHARS) - 1 - int'(type_pos)) * 8;
            if (acc_type[sh +: 8] != ch) type_ok = 1'b0;
            type_pos = type_pos + 1'b1;
          end else begin
            type_ok = 1'b0;
          end
        end
        if (cur_off < LONG_CHARS) cur_off = cur_off + 1'b1;
      end else begin
        if (cur_field == nrmc_pkg::FIELD_TIME || cur_field == nrmc_pkg::FIELD_LAT ||
            cur_field == nrmc_pkg::FIELD_LON || cur_field == nrmc_pkg::FIELD_DATE)
          cap = LONG_CHARS;
        else
          cap = SHORT_CHARS;
        if (cur_off < cap) begin
          r.store_enable = 1'b1;
          cur_off = cur_off + 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
        if (cur_field == nrmc_pkg::FIELD_LAT) lat_seen = 1'b1;
      end
    end
    r.sentence_is_rmc  = last && type_ok && (type_pos == nrmc_pkg::TYPE_CHARS);
    r.latitude_present = last && lat_seen;
    if (last) clear_sentence();
    return r;
  endfunction

  task automatic check_result(input nrmc_pkg::result_t got, input nrmc_pkg::result_t want);
    if (got.field_number != want.field_number)
      report_mismatch("field_number", 32'(got.field_number), 32'(want.field_number));
    if (got.char_offset != want.char_offset)
      report_mismatch("char_offset", 32'(got.char_offset), 32'(want.char_offset));
    if (got.char_value != want.char_value)
      report_mismatch("char_value", 32'(got.char_value), 32'(want.char_value));
    if (got.store_enable != want.store_enable)
      report_mismatch("store_enable", 32'(got.store_enable), 32'(want.store_enable));
    if (got.overflow != want.overflow)
      report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
    if (got.is_last != want.is_last)
      report_mismatch("is_last", 32'(got.is_last), 32'(want.is_last));
    if (got.sentence_is_rmc != want.sentence_is_rmc)
      report_mismatch("sentence_is_rmc", 32'(got.sentence_is_rmc),
                      32'(want.sentence_is_rmc));
    if (got.latitude_present != want.latitude_present)
      report_mismatch("latitude_present", 32'(got.latitude_present),
                      32'(want.latitude_present));
  endtask

  // byte source: predicts each accepted request, then offers the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (on_bus.typed) begin
          void'(split_byte(on_bus.ch, on_bus.last));
          pending_q.push_back(on_bus.want);
        end else begin
          pending_q.push_back(split_byte(on_bus.ch, on_bus.last));
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          on_bus = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= on_bus.ch;
          s_axis_tlast  <= on_bus.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink
  always @(posedge clk_i) begin
    nrmc_pkg::result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.field_number     = m_axis_tdata[3:0];
        got.char_offset      = m_axis_tdata[8:4];
        got.char_value       = m_axis_tdata[16:9];
        got.store_enable     = m_axis_tdata[17];
        got.overflow         = m_axis_tdata[18];
        got.sentence_is_rmc  = m_axis_tdata[19];
        got.latitude_present = m_axis_tdata[20];
        got.is_last          = m_axis_tlast;
        if (pending_q.size() == 0)
          report_mismatch("result with nothing pending", 32'(m_axis_tdata), 0);
        else
          check_result(got, pending_q.pop_front());
      end
      m_axis_tready <= !sink_blocked && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up onto its input
  initial begin
    wait (hold_arm);
    @(posedge clk_i);
    sink_blocked <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_blocked <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic add_row(input logic [7:0] ch, input logic last, input logic typed,
                         input nrmc_pkg::result_t want);
    byte_req_t r;
    r.ch    = ch;
    r.last  = last;
    r.typed = typed;
    r.want  = want;
    table_rows.push_back(r);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((byte_q.size() != 0 || s_axis_tvalid || pending_q.size() != 0) &&
           guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_q.size() != 0) begin
      report_mismatch("results never delivered", pending_q.size(), 0);
      pending_q.delete();
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_type(input logic [nrmc_pkg::TYPE_W-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    acc_type = v;
  endtask

  function automatic logic [7:0] data_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == nrmc_pkg::COMMA_CHAR);
    return c;
  endfunction

  // one sentence, mostly well formed, sometimes plain noise; returns its length
  task automatic queue_sentence(output int n_bytes);
    logic [7:0] sq[$];
    byte_req_t  r;
    int         k, n, f, nf, len, cap;
    if ($urandom_range(99) < 80) begin
      k = $urandom_range(99);
      if (k < 70) begin
        for (n = 0; n < 6; n++) sq.push_back(acc_type[8*(5-n) +: 8]);
      end else if (k < 80) begin
        for (n = 0; n < 6; n++) sq.push_back(acc_type[8*(5-n) +: 8]);
        sq[$urandom_range(5)] = data_char();
      end else if (k < 88) begin
        for (n = 0; n < 5; n++) sq.push_back(acc_type[8*(5-n) +: 8]);
      end else if (k < 94) begin
        for (n = 0; n < 6; n++) sq.push_back(acc_type[8*(5-n) +: 8]);
        sq.push_back(data_char());
      end
      k = $urandom_range(99);
      if (k < 60) nf = 9;
      else if (k < 85) nf = $urandom_range(12, 10);
      else nf = $urandom_range(8, 0);
      for (f = 1; f <= nf; f++) begin
        sq.push_back(nrmc_pkg::COMMA_CHAR);
        if (f == 2 || f == 4 || f == 6 || f == 7 || f == 8) cap = SHORT_CHARS;
        else cap = LONG_CHARS;
        k = $urandom_range(99);
        if (k < 30) len = 0;
        else if (k < 85) len = $urandom_range(3, 1);
        else if (k < 95) len = $urandom_range(cap, 4);
        else len = $urandom_range(cap + 3, cap + 1);
        for (n = 0; n < len; n++) sq.push_back(data_char());
      end
    end else begin
      len = $urandom_range(30, 1);
      for (n = 0; n < len; n++)
        sq.push_back(($urandom_range(4) == 0) ? nrmc_pkg::COMMA_CHAR
                                              : 8'($urandom_range(255)));
    end
    if (sq.size() == 0) sq.push_back(nrmc_pkg::COMMA_CHAR);
    for (n = 0; n < sq.size(); n++) begin
      r.ch    = sq[n];
      r.last  = (n == sq.size() - 1);
      r.typed = 1'b0;
      r.want  = '0;
      byte_q.push_back(r);
    end
    n_bytes = sq.size();
  endtask

  initial begin
    logic [63:0]                 r64;
    logic [nrmc_pkg::TYPE_W-1:0] v;
    int                          ph, cnt, got_n, i;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    acc_type      = nrmc_pkg::TYPE_RESET;
    clear_sentence();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // exact match on the reset type, overflow in a short field, full bytes in latitude
    add_row(8'h24, 1'b0, 1'b1,
            '{nrmc_pkg::FIELD_TYPE, 5'd0, 8'h24, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(8'h47, 1'b0, 1'b0, '0);
    add_row(8'h50, 1'b0, 1'b0, '0);
    add_row(8'h52, 1'b0, 1'b0, '0);
    add_row(8'h4D, 1'b0, 1'b0, '0);
    add_row(8'h43, 1'b0, 1'b0, '0);
    add_row(nrmc_pkg::COMMA_CHAR, 1'b0, 1'b1,
            '{nrmc_pkg::FIELD_TIME, 5'd0, nrmc_pkg::COMMA_CHAR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(nrmc_pkg::COMMA_CHAR, 1'b0, 1'b1,
            '{FIELD_VALID, 5'd0, nrmc_pkg::COMMA_CHAR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    for (i = 0; i < SHORT_CHARS; i++) add_row(8'(8'h41 + i), 1'b0, 1'b0, '0);
    add_row(8'h7F, 1'b0, 1'b1,
            '{FIELD_VALID, 5'(SHORT_CHARS), 8'h7F, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    add_row(nrmc_pkg::COMMA_CHAR, 1'b0, 1'b1,
            '{nrmc_pkg::FIELD_LAT, 5'd0, nrmc_pkg::COMMA_CHAR, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(8'hFF, 1'b0, 1'b1,
            '{nrmc_pkg::FIELD_LAT, 5'd0, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(nrmc_pkg::COMMA_CHAR, 1'b1, 1'b1,
            '{FIELD_NS, 5'd0, nrmc_pkg::COMMA_CHAR, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1});
    // one-byte sentence: type far too short
    add_row(8'h00, 1'b1, 1'b1,
            '{nrmc_pkg::FIELD_TYPE, 5'd0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    // empty type field
    add_row(nrmc_pkg::COMMA_CHAR, 1'b1, 1'b1,
            '{nrmc_pkg::FIELD_TIME, 5'd0, nrmc_pkg::COMMA_CHAR, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0});
    foreach (table_rows[j]) byte_q.push_back(table_rows[j]);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: v = nrmc_pkg::TYPE_RESET;
        1: v = '0;
        2: v = '1;
        4: v = TYPE_GNRMC;
        default: begin
          r64 = {$urandom(), $urandom()};
          v   = r64[nrmc_pkg::TYPE_W-1:0];
        end
      endcase
      write_type(v);
      if (ph < 2) begin
        src_idle_pct = 26;
        snk_idle_pct = 62;
      end else if (ph < 4) begin
        src_idle_pct = 62;
        snk_idle_pct = 26;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      cnt = 0;
      while (cnt < PHASE_BYTES) begin
        queue_sentence(got_n);
        cnt += got_n;
      end
      if (ph == 4) hold_arm = 1'b1;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
